// File: rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// shared types and constants of the broadcast byte ring
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int POS_W    = 32;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 2;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DATA   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LAGGED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOD,
      ST_FETCH,
      ST_STREAM,
      ST_STATUS
   } state_type;

endpackage

// File: rtl/broadcast_ring_buffer.sv
// ----------------------------------------------------------------------------
// broadcast_ring_buffer
// single writer, many reader byte ring with per-request read bursts
// ----------------------------------------------------------------------------
// A write word stores one byte and is taken while the block is idle. A read
// word is taken and has the reader's distance checked, then, if data is due,
// goes through the compare-and-subtract unit that maps the reader's position
// to a ring slot, fetches the first byte from the ring memory's single read
// port, then streams one byte per cycle unless the result side stalls.
// A status reply is sent after the distance check when no data is due.
// The store needs no clearing pass after reset: a fill count makes slots not
// yet written read as zero. The input is not ready while a read is in work.
module broadcast_ring_buffer #(
   parameter int RING_BYTES = 4096,
   parameter int MAX_READ   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // write_byte, client_position, max_length, zero pad
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // data_byte, new_position
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast
);

   localparam int SW = $clog2(RING_BYTES);
   localparam int CW = $clog2(MAX_READ + 1);
   localparam int PW = brb_pkg::POS_W;

   brb_pkg::state_type state_ff, state_in;

   logic [PW-1:0]              wr_pos_ff, wr_pos_in;
   logic [SW-1:0]              wr_slot_ff, wr_slot_in;
   logic [PW-1:0]              cpos_ff, dist_ff, newpos_ff, rd_pos_ff, rd_pos_in;
   logic [brb_pkg::LEN_W-1:0]  maxlen_ff;
   logic [CW-1:0]              count_ff, count_in, left_ff, left_in;
   logic [SW-1:0]              rd_slot_ff, rd_slot_in;
   logic [brb_pkg::STATUS_W-1:0] stat_ff, stat_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [brb_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic [PW-1:0]                rsp_pos_ff, rsp_pos_in;
   logic [brb_pkg::STATUS_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                       accept, out_free, load_data, load_status;
   logic                       mem_we, mem_re, mod_start, mod_done;
   logic [SW-1:0]              mod_rem;
   logic [brb_pkg::BYTE_W-1:0] mem_rd_data;
   logic                       is_empty, is_lagged, no_data;
   logic [PW-1:0]              lim, cnt_full;

   logic [PW-1:0] req_pos;
   logic [brb_pkg::BYTE_W-1:0] req_byte;
   logic [brb_pkg::LEN_W-1:0]  req_len;

   assign req_byte = req_tdata[7:0];
   assign req_pos  = req_tdata[39:8];
   assign req_len  = req_tdata[45:40];

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign is_empty  = (dist_ff == '0) || dist_ff[PW-1];
   assign is_lagged = dist_ff > PW'(RING_BYTES);
   assign no_data   = is_empty || is_lagged || (maxlen_ff == '0);
   assign lim       = (PW'(maxlen_ff) > PW'(MAX_READ)) ? PW'(MAX_READ) : PW'(maxlen_ff);
   assign cnt_full  = (dist_ff < lim) ? dist_ff : lim;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (accept && (req_tuser == brb_pkg::ACTION_READ)) begin
               state_in = brb_pkg::ST_CHECK;
            end
         end
         brb_pkg::ST_CHECK: begin
            state_in = no_data ? brb_pkg::ST_STATUS : brb_pkg::ST_MOD;
         end
         brb_pkg::ST_MOD: begin
            if (mod_done) begin
               state_in = brb_pkg::ST_FETCH;
            end
         end
         brb_pkg::ST_FETCH: begin
            state_in = brb_pkg::ST_STREAM;
         end
         brb_pkg::ST_STREAM: begin
            if (out_free && (left_ff == '0)) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         brb_pkg::ST_STATUS: begin
            if (out_free) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         default: state_in = brb_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mod_start   = 1'b0;
      load_data   = 1'b0;
      load_status = 1'b0;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            mem_we     = accept && (req_tuser == brb_pkg::ACTION_WRITE);
         end
         brb_pkg::ST_CHECK: begin
            mod_start = !no_data;
         end
         brb_pkg::ST_MOD: begin
         end
         brb_pkg::ST_FETCH: begin
            mem_re = 1'b1;
         end
         brb_pkg::ST_STREAM: begin
            load_data = out_free;
            mem_re    = out_free && (left_ff != '0);
         end
         brb_pkg::ST_STATUS: begin
            load_status = out_free;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      wr_pos_in  = wr_pos_ff;
      wr_slot_in = wr_slot_ff;
      if (mem_we) begin
         wr_pos_in = wr_pos_ff + 1'b1;
         if ((wr_pos_in == '0) || (wr_slot_ff == SW'(RING_BYTES - 1))) begin
            wr_slot_in = '0;
         end else begin
            wr_slot_in = wr_slot_ff + 1'b1;
         end
      end

      stat_in  = stat_ff;
      count_in = count_ff;
      if (state_ff == brb_pkg::ST_CHECK) begin
         stat_in  = (!is_empty && is_lagged) ? brb_pkg::STATUS_LAGGED : brb_pkg::STATUS_EMPTY;
         count_in = cnt_full[CW-1:0];
      end

      rd_pos_in  = rd_pos_ff;
      rd_slot_in = rd_slot_ff;
      left_in    = left_ff;
      if (mod_done) begin
         rd_pos_in  = cpos_ff;
         rd_slot_in = mod_rem;
         left_in    = count_ff;
      end else if (mem_re) begin
         rd_pos_in = rd_pos_ff + 1'b1;
         left_in   = left_ff - 1'b1;
         if ((rd_pos_in == '0) || (rd_slot_ff == SW'(RING_BYTES - 1))) begin
            rd_slot_in = '0;
         end else begin
            rd_slot_in = rd_slot_ff + 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_data) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = mem_rd_data;
         rsp_pos_in   = newpos_ff;
         rsp_stat_in  = brb_pkg::STATUS_DATA;
         rsp_last_in  = (left_ff == '0);
      end else if (load_status) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = '0;
         rsp_pos_in   = cpos_ff;
         rsp_stat_in  = stat_ff;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brb_pkg::ST_IDLE;
         wr_pos_ff    <= '0;
         wr_slot_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         wr_slot_ff   <= wr_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_tuser == brb_pkg::ACTION_READ)) begin
         cpos_ff   <= req_pos;
         maxlen_ff <= req_len;
         dist_ff   <= wr_pos_ff - req_pos;
      end
      newpos_ff   <= cpos_ff + PW'(count_ff);
      stat_ff     <= stat_in;
      count_ff    <= count_in;
      rd_pos_ff   <= rd_pos_in;
      rd_slot_ff  <= rd_slot_in;
      left_ff     <= left_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   brb_mod_unit #(
      .RING_BYTES (RING_BYTES)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .position  (wr_pos_ff),
      .slot      (wr_slot_ff),
      .distance  (dist_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   brb_ring_mem #(
      .RING_BYTES (RING_BYTES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (wr_slot_ff),
      .wr_data (req_byte),
      .rd_en   (mem_re),
      .rd_addr (rd_slot_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/brb_mod_unit.sv
// ----------------------------------------------------------------------------
// brb_mod_unit
// ring slot of a reader's position, by compare and subtract from the write slot
// ----------------------------------------------------------------------------
module brb_mod_unit #(
   parameter int RING_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [brb_pkg::POS_W-1:0]       position,  // write position
   input  logic [$clog2(RING_BYTES)-1:0]   slot,      // slot of the write position
   input  logic [brb_pkg::POS_W-1:0]       distance,  // write position less reader position
   output logic                            done,
   output logic [$clog2(RING_BYTES)-1:0]   remainder
);

   localparam int SW = $clog2(RING_BYTES);
   localparam int RW = SW + 2;
   localparam logic [RW-1:0] RING_SIZE = RW'(RING_BYTES);
   // 2^32 mod ring size, added when the reader sits before the position wrap
   localparam logic [RW-1:0] WRAP_REM = RW'((64'd1 << brb_pkg::POS_W) % 64'(RING_BYTES));

   logic          sub_ff, sub_in;
   logic          fix_ff, fix_in;
   logic          done_ff, done_in;
   logic [RW-1:0] acc_ff, acc_in;

   // distance is at most one ring here, so one correction brings the slot in range
   always_comb begin
      sub_in  = start;
      fix_in  = sub_ff;
      done_in = fix_ff;
      acc_in  = acc_ff;
      if (start) begin
         acc_in = (position < distance) ? RW'(slot) + WRAP_REM : RW'(slot);
      end else if (sub_ff) begin
         acc_in = acc_ff - RW'(distance);
      end else if (fix_ff) begin
         if (acc_ff[RW-1]) begin
            acc_in = acc_ff + RING_SIZE;
         end else if (acc_ff >= RING_SIZE) begin
            acc_in = acc_ff - RING_SIZE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         sub_ff  <= sub_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
   end

   assign done      = done_ff;
   assign remainder = acc_ff[SW-1:0];

endmodule

// File: rtl/brb_ring_mem.sv
// ----------------------------------------------------------------------------
// brb_ring_mem
// byte store of the ring; slots not yet written read as zero
// ----------------------------------------------------------------------------
module brb_ring_mem #(
   parameter int RING_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [$clog2(RING_BYTES)-1:0]   wr_addr,
   input  logic [brb_pkg::BYTE_W-1:0]      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(RING_BYTES)-1:0]   rd_addr,
   output logic [brb_pkg::BYTE_W-1:0]      rd_data
);

   localparam int SW = $clog2(RING_BYTES);

   logic [brb_pkg::BYTE_W-1:0] mem [RING_BYTES];
   logic [brb_pkg::BYTE_W-1:0] q_ff;
   logic                       hit_ff;
   logic [SW:0]                fill_ff, fill_in;

   // writes fill the slots in order from zero, so a count tells which are valid
   always_comb begin
      fill_in = fill_ff;
      if (wr_en && (fill_ff != (SW+1)'(RING_BYTES))) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff   <= mem[rd_addr];
         hit_ff <= ({1'b0, rd_addr} < fill_ff);
      end
   end

   assign rd_data = hit_ff ? q_ff : '0;

endmodule
